// ----- hw/rtl/irc_pkg.sv -----
package irc_pkg;

  localparam int unsigned MAX_PAIRS    = 64;
  localparam int unsigned NUM_CHANNELS = 2;

  localparam int unsigned CH_W   = 1;
  localparam int unsigned PAIR_W = 6;
  localparam int unsigned SLOT_W = PAIR_W + 1;
  localparam int unsigned IDX_W  = SLOT_W + 1;
  localparam int unsigned ENT_W  = 10;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned LIM_W  = 16;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned REG_W  = 1;
  localparam int unsigned DATA_W = 16;

  localparam logic [IDX_W-1:0]  SLOTS       = IDX_W'(2 * MAX_PAIRS);
  localparam logic [ENT_W-1:0]  ENTRY_MAX   = '1;
  localparam logic [LIM_W-1:0]  GAP_LIMIT_RST = LIM_W'(5000);
  localparam logic [ACT_W-1:0]  ACTIVE_RST  = ACT_W'(NUM_CHANNELS);

  typedef enum logic [1:0] {
    OP_EDGE   = 2'd0,
    OP_POLL   = 2'd1,
    OP_RESUME = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [REG_W-1:0] {
    REG_ACTIVE_CHANNELS = 1'd0,
    REG_GAP_LIMIT       = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic              en;
    logic [CH_W-1:0]   ch;
    logic [SLOT_W-1:0] slot;
    logic [ENT_W-1:0]  data;
  } wr_req_t;

endpackage

// ----- hw/rtl/irc_item_if.sv -----
interface irc_item_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         operation;
  logic [irc_pkg::CH_W-1:0]           channel;
  logic [irc_pkg::TIME_W-1:0]         now_us;
  logic [irc_pkg::PAIR_W-1:0]         pair_index;

  modport source (output valid, operation, channel, now_us, pair_index, input ready);
  modport sink   (input valid, operation, channel, now_us, pair_index, output ready);
endinterface

// ----- hw/rtl/irc_result_if.sv -----
interface irc_result_if;
  logic                        valid;
  logic                        ready;
  logic [irc_pkg::CNT_W-1:0]   pair_count;
  logic [irc_pkg::DUR_W-1:0]   first_duration;
  logic [irc_pkg::DUR_W-1:0]   second_duration;

  modport source (output valid, pair_count, first_duration, second_duration, input ready);
  modport sink   (input valid, pair_count, first_duration, second_duration, output ready);
endinterface

// ----- hw/rtl/irc_cfg_if.sv -----
interface irc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [irc_pkg::REG_W-1:0]   index;
  logic [irc_pkg::DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/irc_pair_store.sv -----
module irc_pair_store (
  input  logic                            clk,
  input  logic                            rst,
  input  irc_pkg::wr_req_t                wr,
  input  logic                            rd_en,
  input  logic [irc_pkg::CH_W-1:0]        rd_ch,
  input  logic [irc_pkg::PAIR_W-1:0]      rd_pair,
  output logic [irc_pkg::ENT_W-1:0]       rd_first,
  output logic [irc_pkg::ENT_W-1:0]       rd_second
);

  localparam int unsigned ROW_W = irc_pkg::CH_W + irc_pkg::PAIR_W;
  localparam int unsigned ROWS  = 2 ** ROW_W;

  // even and odd slots live in separate banks so both halves of a pair are read together
  logic [irc_pkg::ENT_W-1:0] even_mem [ROWS];
  logic [irc_pkg::ENT_W-1:0] odd_mem  [ROWS];
  logic [ROWS-1:0]           even_vld;
  logic [ROWS-1:0]           odd_vld;

  logic [ROW_W-1:0]          wr_row;
  logic [ROW_W-1:0]          rd_row;
  logic [irc_pkg::ENT_W-1:0] even_q;
  logic [irc_pkg::ENT_W-1:0] odd_q;
  logic                      even_vq;
  logic                      odd_vq;

  assign wr_row = {wr.ch, wr.slot[irc_pkg::SLOT_W-1:1]};
  assign rd_row = {rd_ch, rd_pair};

  always_ff @(posedge clk) begin
    if (wr.en && !wr.slot[0]) begin
      even_mem[wr_row] <= wr.data;
    end
    if (wr.en && wr.slot[0]) begin
      odd_mem[wr_row] <= wr.data;
    end
    if (rd_en) begin
      even_q <= even_mem[rd_row];
      odd_q  <= odd_mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      even_vld <= '0;
      odd_vld  <= '0;
      even_vq  <= 1'b0;
      odd_vq   <= 1'b0;
    end else begin
      if (wr.en && !wr.slot[0]) begin
        even_vld[wr_row] <= 1'b1;
      end
      if (wr.en && wr.slot[0]) begin
        odd_vld[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        even_vq <= even_vld[rd_row];
        odd_vq  <= odd_vld[rd_row];
      end
    end
  end

  assign rd_first  = even_vq ? even_q : '0;
  assign rd_second = odd_vq  ? odd_q  : '0;

endmodule

// ----- hw/rtl/ir_edge_interval_capture_core.sv -----
// Infrared edge-interval capture for two receiver channels. Each word on the item channel
// is an edge, a poll, a resume or a pair read, and gets exactly one result word. The block
// is a two-register pipeline: an input register, then the result register whose read data
// comes from a registered two-bank (even/odd slot) store; a new item is accepted every
// cycle while the result side keeps up. Per-channel index and timestamp state is updated
// in the cycle an item leaves the input register, so consecutive items on the same
// channel see each other's effects.
// Configuration writes are taken at any time and should only be issued while idle.
module ir_edge_interval_capture_core (
  input  logic              clk,
  input  logic              rst,
  irc_item_if.sink          item,
  irc_result_if.source      result,
  irc_cfg_if.sink           cfg
);

  // configuration
  logic [irc_pkg::ACT_W-1:0] active_channels;
  logic [irc_pkg::LIM_W-1:0] gap_limit_us;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= irc_pkg::ACTIVE_RST;
      gap_limit_us    <= irc_pkg::GAP_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (irc_pkg::reg_idx_t'(cfg.index))
        irc_pkg::REG_ACTIVE_CHANNELS: active_channels <= cfg.data[irc_pkg::ACT_W-1:0];
        irc_pkg::REG_GAP_LIMIT:       gap_limit_us    <= cfg.data[irc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic advance;
  logic s1_valid;
  logic s2_valid;

  assign advance     = !s2_valid || result.ready;
  assign item.ready  = !s1_valid || advance;

  // input register
  irc_pkg::op_t                s1_op;
  logic [irc_pkg::CH_W-1:0]    s1_ch;
  logic [irc_pkg::TIME_W-1:0]  s1_now;
  logic [irc_pkg::PAIR_W-1:0]  s1_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_op   <= irc_pkg::op_t'(item.operation);
      s1_ch   <= item.channel;
      s1_now  <= item.now_us;
      s1_pair <= item.pair_index;
    end
  end

  // per-channel state
  logic [irc_pkg::NUM_CHANNELS-1:0] armed;
  logic [irc_pkg::IDX_W-1:0]        widx     [irc_pkg::NUM_CHANNELS];
  logic [irc_pkg::TIME_W-1:0]       prev_time[irc_pkg::NUM_CHANNELS];
  logic [irc_pkg::CNT_W-1:0]        rep_pairs[irc_pkg::NUM_CHANNELS];

  logic                       cur_armed;
  logic [irc_pkg::IDX_W-1:0]  cur_widx;
  logic [irc_pkg::TIME_W-1:0] cur_prev;
  logic [irc_pkg::CNT_W-1:0]  cur_rep;

  assign cur_armed = armed[s1_ch];
  assign cur_widx  = widx[s1_ch];
  assign cur_prev  = prev_time[s1_ch];
  assign cur_rep   = rep_pairs[s1_ch];

  logic                       ch_ok;
  logic [irc_pkg::TIME_W-1:0] gap;
  logic                       gap_gt;
  logic                       gap_lt;
  logic [irc_pkg::ENT_W-1:0]  gap_ent;

  // channel 0 needs at least one active channel, channel 1 needs two or more
  assign ch_ok   = (s1_ch == '0) ? (active_channels != '0) : (active_channels >= 2'd2);
  assign gap     = s1_now - cur_prev;
  assign gap_gt  = gap > irc_pkg::TIME_W'(gap_limit_us);
  assign gap_lt  = gap < irc_pkg::TIME_W'(gap_limit_us);
  assign gap_ent = (gap[irc_pkg::TIME_W-1:irc_pkg::ENT_W+3] != '0) ? irc_pkg::ENTRY_MAX
                                                                  : gap[irc_pkg::ENT_W+2:3];

  logic                       armed_next;
  logic [irc_pkg::IDX_W-1:0]  widx_next;
  logic [irc_pkg::TIME_W-1:0] prev_next;
  logic [irc_pkg::CNT_W-1:0]  rep_next;
  logic [irc_pkg::CNT_W-1:0]  count_next;
  logic [irc_pkg::IDX_W-1:0]  w0;
  logic [irc_pkg::IDX_W-1:0]  w1;
  irc_pkg::wr_req_t           wr_req;
  irc_pkg::wr_req_t           wr_gated;

  always_comb begin
    armed_next  = cur_armed;
    widx_next   = cur_widx;
    prev_next   = cur_prev;
    rep_next    = cur_rep;
    count_next  = '0;
    w0          = cur_widx;
    w1          = cur_widx;
    wr_req      = '0;
    wr_req.ch   = s1_ch;
    if (ch_ok) begin
      unique case (s1_op)
        irc_pkg::OP_EDGE: begin
          if (cur_armed) begin
            // a long gap restarts the capture at slot zero
            w0 = (cur_widx != '0 && gap_gt) ? '0 : cur_widx;
            w1 = w0;
            if (gap_lt && w0 < irc_pkg::SLOTS) begin
              wr_req.en   = 1'b1;
              wr_req.slot = w0[irc_pkg::SLOT_W-1:0];
              wr_req.data = gap_ent;
              w1          = w0 + 1'b1;
            end
            prev_next = s1_now;
            if (w1 >= irc_pkg::SLOTS) begin
              armed_next = 1'b0;
              widx_next  = irc_pkg::SLOTS - 1'b1;
            end else begin
              widx_next = w1;
            end
          end
        end
        irc_pkg::OP_POLL: begin
          if (cur_armed) begin
            if (cur_widx != '0 && gap_gt) begin
              armed_next = 1'b0;
              w1         = cur_widx;
              // pad a zero space so the last pair is complete
              if (cur_widx[0] && cur_widx < irc_pkg::SLOTS) begin
                wr_req.en   = 1'b1;
                wr_req.slot = cur_widx[irc_pkg::SLOT_W-1:0];
                wr_req.data = '0;
                w1          = cur_widx + 1'b1;
              end
              widx_next  = w1;
              rep_next   = w1[irc_pkg::IDX_W-1:1];
              count_next = w1[irc_pkg::IDX_W-1:1];
            end
          end else if (cur_rep == '0) begin
            if (cur_widx == irc_pkg::IDX_W'(1)) begin
              widx_next  = '0;
              armed_next = 1'b1;
            end else begin
              rep_next   = cur_widx[irc_pkg::IDX_W-1:1];
              count_next = cur_widx[irc_pkg::IDX_W-1:1];
            end
          end
        end
        irc_pkg::OP_RESUME: begin
          rep_next   = '0;
          prev_next  = '0;
          widx_next  = '0;
          armed_next = 1'b1;
        end
        irc_pkg::OP_READ: ;
        default: ;
      endcase
    end
  end

  logic proc;
  assign proc = s1_valid && advance;

  always_comb begin
    wr_gated    = wr_req;
    wr_gated.en = wr_req.en && proc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < irc_pkg::NUM_CHANNELS; c++) begin
        armed[c]     <= 1'b1;
        widx[c]      <= '0;
        prev_time[c] <= '0;
        rep_pairs[c] <= '0;
      end
    end else if (proc && ch_ok) begin
      armed[s1_ch]     <= armed_next;
      widx[s1_ch]      <= widx_next;
      prev_time[s1_ch] <= prev_next;
      rep_pairs[s1_ch] <= rep_next;
    end
  end

  logic [irc_pkg::ENT_W-1:0] rd_first;
  logic [irc_pkg::ENT_W-1:0] rd_second;

  irc_pair_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr_gated),
    .rd_en     (advance),
    .rd_ch     (s1_ch),
    .rd_pair   (s1_pair),
    .rd_first  (rd_first),
    .rd_second (rd_second)
  );

  // result register
  logic                      s2_read;
  logic [irc_pkg::CNT_W-1:0] s2_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_read  <= ch_ok && (s1_op == irc_pkg::OP_READ);
      s2_count <= count_next;
    end
  end

  assign result.valid           = s2_valid;
  assign result.pair_count      = s2_count;
  assign result.first_duration  = s2_read ? {3'b000, rd_first, 3'b000}  : '0;
  assign result.second_duration = s2_read ? {3'b000, rd_second, 3'b000} : '0;

  // index never passes the buffer end, even after padding
  a_widx_bound: assert property (@(posedge clk) disable iff (rst)
    widx[0] <= irc_pkg::SLOTS && widx[1] <= irc_pkg::SLOTS)
    else $error("write index past buffer end");

  // durations are only nonzero on a read result
  a_dur_read_only: assert property (@(posedge clk) disable iff (rst)
    s2_valid && (result.first_duration != '0 || result.second_duration != '0) |-> s2_read)
    else $error("duration on non-read result");

  // a store write happens only when an item leaves the input register
  a_wr_proc: assert property (@(posedge clk) disable iff (rst)
    wr_gated.en |-> s1_valid && advance && ch_ok)
    else $error("store write without item");

endmodule
